// ----- src/three_channel_sensor_alarm_monitor_macros.svh -----
// Assertion macros used by the sensor alarm monitor RTL.
`ifndef THREE_CHANNEL_SENSOR_ALARM_MONITOR_MACROS_SVH
`define THREE_CHANNEL_SENSOR_ALARM_MONITOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TCSAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcsam assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TCSAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcsam assertion failed");

`endif

// ----- src/tcsam_pkg.sv -----
// Package with types and constants of the three-channel sensor alarm monitor.
`timescale 1ns / 1ps
`default_nettype none
package tcsam_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SAMPLE_BITS = 12;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
      SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

   localparam int PCT_W    = 7;
   localparam int COUNT_W  = 2;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 16;
   localparam int CSR_W    = 36;
   localparam int CSR_IDX_W = 3;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam logic [PERIOD_W-1:0] PERIOD_ONE_RESET   = 16'd500;
   localparam logic [PERIOD_W-1:0] PERIOD_TWO_RESET   = 16'd200;
   localparam logic [PERIOD_W-1:0] PERIOD_THREE_RESET = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_A     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_B     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_C     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_ONE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TWO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_THR = 3'd6;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
      logic [TIME_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [PCT_W-1:0]   percent_a;
      logic [PCT_W-1:0]   percent_b;
      logic [PCT_W-1:0]   percent_c;
      logic [COUNT_W-1:0] alarm_count;
      logic               led_level;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/three_channel_sensor_alarm_monitor.sv -----
// Top level of the three-channel sensor alarm monitor.
// Per item, each channel takes a single SETUP step when its percent is a clamp value,
// or SETUP followed by the DIVIDE steps when the shared 7-step restoring divider runs;
// the LED and DONE steps then follow before the result is valid.
// One item is in work at a time; a new item is accepted only while the block is idle.
// Reset is synchronous and active high; it sets the control and configuration registers, not the payload registers.
`timescale 1ns / 1ps
`default_nettype none
`include "three_channel_sensor_alarm_monitor_macros.svh"
module three_channel_sensor_alarm_monitor (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire tcsam_pkg::req_type         req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output tcsam_pkg::rsp_type              rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [tcsam_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcsam_pkg::CSR_W-1:0] csr_data
);
   import tcsam_pkg::*;

   // The sequencer walks the three channels one after another. SETUP works out
   // the alarm test and the clamp cases for the current channel and loads the
   // divider; DIVIDE produces one quotient bit a cycle; LED updates the blink
   // timer; DONE waits for the output register to be free.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_LED    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   localparam int NUM_W = SAMPLE_W + PCT_W;   // holds a difference times 100

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CSR_W-1:0]    chan_a_ff, chan_b_ff, chan_c_ff, hyst_ff;
   logic [PERIOD_W-1:0] period_one_ff, period_two_ff, period_three_ff;

   // Blink state.
   logic [TIME_W-1:0]   last_toggle_ff;
   logic [PERIOD_W-1:0] blink_period_ff;
   logic                led_ff;

   // Working registers for one item.
   req_type             item_ff;
   logic [1:0]          ch_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [PCT_W-1:0]    pct_ff [3];
   logic [NUM_W-1:0]    rem_ff;
   logic [NUM_W-1:0]    dsh_ff;
   logic [SAMPLE_W-1:0] den_ff;
   logic [PCT_W-1:0]    quo_ff;
   logic [2:0]          step_ff;
   logic                inv_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Channel selection for the setup step.
   logic [SAMPLE_W-1:0] s, lo, hi, trig, hyst;
   logic [SAMPLE_W:0]   limit;
   logic                falling, alarm;
   logic [SAMPLE_W-1:0] diff_rise, diff_fall, diff_sel, den_sel;
   logic [NUM_W-1:0]    num_sel;
   logic                direct, need_div, inv_sel;
   logic [PCT_W-1:0]    direct_pct;

   // Divider step.
   logic                fits;
   logic [PCT_W-1:0]    quo_next, div_pct;

   // LED step.
   logic [TIME_W-1:0]   elapsed;
   logic [PERIOD_W-1:0] period_sel;

   logic req_accept, rsp_take, out_free;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      case (ch_ff)
         2'd0: begin
            s    = item_ff.sample_a & SAMPLE_MASK;
            lo   = chan_a_ff[11:0];
            hi   = chan_a_ff[23:12];
            trig = chan_a_ff[35:24];
            hyst = hyst_ff[11:0];
         end
         2'd1: begin
            s    = item_ff.sample_b & SAMPLE_MASK;
            lo   = chan_b_ff[11:0];
            hi   = chan_b_ff[23:12];
            trig = chan_b_ff[35:24];
            hyst = hyst_ff[23:12];
         end
         default: begin
            s    = item_ff.sample_c & SAMPLE_MASK;
            lo   = chan_c_ff[11:0];
            hi   = chan_c_ff[23:12];
            trig = chan_c_ff[35:24];
            hyst = hyst_ff[35:24];
         end
      endcase
   end

   always_comb begin
      falling   = (lo > hi);
      limit     = {1'b0, trig} + {1'b0, hyst};
      alarm     = falling ? ({1'b0, s} <= limit) : ({1'b0, s} >= limit);
      diff_rise = s - lo;
      diff_fall = s - hi;
      direct     = 1'b1;
      direct_pct = '0;
      inv_sel    = 1'b0;
      diff_sel   = diff_rise;
      den_sel    = hi - lo;
      // A falling range reads 0 when the sample equals end; only a sample
      // strictly below end reads as full scale.
      if (falling && (hi < s)) begin
         if (s < lo) begin
            direct   = 1'b0;
            inv_sel  = 1'b1;
            diff_sel = diff_fall;
            den_sel  = lo - hi;
         end
      end else if ((lo < s) && (hi > lo)) begin
         if (s >= hi) begin
            direct_pct = PCT_FULL;
         end else begin
            direct = 1'b0;
         end
      end else if (falling && (s < hi)) begin
         direct_pct = PCT_FULL;
      end
      need_div = !direct;
      // Times 100 as 64 + 32 + 4.
      num_sel = {1'b0, diff_sel, 6'b0} + {2'b0, diff_sel, 5'b0} + {5'b0, diff_sel, 2'b0};
   end

   always_comb begin
      fits     = (rem_ff >= dsh_ff);
      quo_next = quo_ff | (fits ? PCT_W'(7'd1 << step_ff) : '0);
      div_pct  = inv_ff ? (PCT_FULL - quo_next) : quo_next;
   end

   always_comb begin
      elapsed = item_ff.now_ms - last_toggle_ff;
      case (cnt_ff)
         2'd1:    period_sel = period_one_ff;
         2'd2:    period_sel = period_two_ff;
         default: period_sel = period_three_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_SETUP;
         ST_SETUP: begin
            if (need_div) begin
               state_in = ST_DIVIDE;
            end else if (ch_ff == 2'd2) begin
               state_in = ST_LED;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == 3'd0) state_in = (ch_ff == 2'd2) ? ST_LED : ST_SETUP;
         end
         ST_LED:    state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chan_a_ff       <= '0;
         chan_b_ff       <= '0;
         chan_c_ff       <= '0;
         hyst_ff         <= '0;
         period_one_ff   <= PERIOD_ONE_RESET;
         period_two_ff   <= PERIOD_TWO_RESET;
         period_three_ff <= PERIOD_THREE_RESET;
         last_toggle_ff  <= '0;
         blink_period_ff <= '0;
         led_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         ch_ff           <= '0;
         cnt_ff          <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_CHAN_A:     chan_a_ff       <= csr_data;
               CSR_CHAN_B:     chan_b_ff       <= csr_data;
               CSR_CHAN_C:     chan_c_ff       <= csr_data;
               CSR_HYSTERESIS: hyst_ff         <= csr_data;
               CSR_PERIOD_ONE: period_one_ff   <= csr_data[PERIOD_W-1:0];
               CSR_PERIOD_TWO: period_two_ff   <= csr_data[PERIOD_W-1:0];
               CSR_PERIOD_THR: period_three_ff <= csr_data[PERIOD_W-1:0];
               default: ;
            endcase
         end

         // A new result may replace the one leaving in the same cycle.
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               ch_ff  <= '0;
               cnt_ff <= '0;
            end
            ST_SETUP: begin
               cnt_ff <= cnt_ff + COUNT_W'(alarm);
               if (!need_div && (ch_ff != 2'd2)) ch_ff <= ch_ff + 2'd1;
            end
            ST_DIVIDE: begin
               if ((step_ff == 3'd0) && (ch_ff != 2'd2)) ch_ff <= ch_ff + 2'd1;
            end
            ST_LED: begin
               // No alarm forces the LED dark and leaves the timer alone.
               if (cnt_ff != '0) begin
                  if (elapsed >= {16'b0, blink_period_ff}) begin
                     blink_period_ff <= period_sel;
                     last_toggle_ff  <= item_ff.now_ms;
                     led_ff          <= !led_ff;
                  end
               end else begin
                  led_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (req_accept) item_ff <= req_data;
      if (state_ff == ST_SETUP) begin
         if (need_div) begin
            rem_ff  <= num_sel;
            dsh_ff  <= {1'b0, den_sel, 6'b0};
            den_ff  <= den_sel;
            quo_ff  <= '0;
            step_ff <= 3'd6;
            inv_ff  <= inv_sel;
         end else begin
            pct_ff[ch_ff] <= direct_pct;
         end
      end
      if (state_ff == ST_DIVIDE) begin
         if (fits) rem_ff <= rem_ff - dsh_ff;
         dsh_ff  <= dsh_ff >> 1;
         quo_ff  <= quo_next;
         step_ff <= step_ff - 3'd1;
         if (step_ff == 3'd0) pct_ff[ch_ff] <= div_pct;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_ff.percent_a   <= pct_ff[0];
         rsp_ff.percent_b   <= pct_ff[1];
         rsp_ff.percent_c   <= pct_ff[2];
         rsp_ff.alarm_count <= cnt_ff;
         rsp_ff.led_level   <= led_ff;
      end
   end

   // An accepted item always starts the channel walk.
   `TCSAM_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == ST_SETUP)
   // The divider never runs with a zero divisor.
   `TCSAM_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == ST_DIVIDE, den_ff != '0)
   // A result with no channel in alarm has a dark LED.
   `TCSAM_ASSERT_NOW(a_led_dark, clock, reset,
      rsp_valid_ff && (rsp_ff.alarm_count == '0), !rsp_ff.led_level)
   // Every reported level lies within full scale.
   `TCSAM_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid_ff,
      (rsp_ff.percent_a <= PCT_FULL) && (rsp_ff.percent_b <= PCT_FULL) &&
      (rsp_ff.percent_c <= PCT_FULL))

endmodule
`default_nettype wire
